>>> src/ild_pkg.sv
// shared types, class codes and opcode class tables for the instruction length decoder
package ild_pkg;

    // longest instruction before the decoder cuts it off
    localparam int MAX_LENGTH = 15;

    // opcode class codes, one nibble per opcode byte
    localparam logic [3:0] CLS_NONE      = 4'h0;
    localparam logic [3:0] CLS_ABS       = 4'h4;
    localparam logic [3:0] CLS_IMMW      = 4'h5;
    localparam logic [3:0] CLS_FAR       = 4'h6;
    localparam logic [3:0] CLS_REL8      = 4'h7;
    localparam logic [3:0] CLS_RELW      = 4'h8;
    localparam logic [3:0] CLS_MODRM     = 4'h9;
    localparam logic [3:0] CLS_MODRM_I8  = 4'hA;
    localparam logic [3:0] CLS_MODRM_IW  = 4'hB;
    localparam logic [3:0] CLS_GRP_I8    = 4'hC;
    localparam logic [3:0] CLS_GRP_IW    = 4'hD;
    localparam logic [3:0] CLS_PREFIX    = 4'hE;
    localparam logic [3:0] CLS_UNKNOWN   = 4'hF;

    // decode phase, one-hot
    typedef enum logic [3:0] {
        PH_PREFIX = 4'b0001,
        PH_MODRM  = 4'b0010,
        PH_SIB    = 4'b0100,
        PH_TAIL   = 4'b1000
    } phase_t;

    // per-instruction decode state
    typedef struct packed {
        phase_t      phase;
        logic [3:0]  op_class;
        logic [1:0]  size_mode;
        logic [7:0]  modrm_byte;
        logic [3:0]  bytes_seen;
        logic [3:0]  bytes_left;
        logic [3:0]  rel_pos;
        logic [2:0]  rel_bytes;
    } state_t;

    localparam state_t STATE_RESET = '{
        phase:      PH_PREFIX,
        op_class:   4'd0,
        size_mode:  2'd1,
        modrm_byte: 8'd0,
        bytes_seen: 4'd0,
        bytes_left: 4'd0,
        rel_pos:    4'd0,
        rel_bytes:  3'd0
    };

    // one finished instruction
    typedef struct packed {
        logic [3:0] length;
        logic       ip_rel;
        logic [3:0] ip_rel_pos;
        logic [2:0] ip_rel_len;
        logic       unknown_op;
        logic       too_long;
    } result_t;

    // class nibbles, low nibble for the even opcode, high nibble for the odd one
    localparam logic [7:0] CLASS_TAB_32 [128] = '{
        8'h99, 8'h99, 8'h51, 8'h00, 8'h99, 8'h99, 8'h51, 8'hf0,
        8'h99, 8'h99, 8'h51, 8'h00, 8'h99, 8'h99, 8'h51, 8'h00,
        8'h99, 8'h99, 8'h51, 8'h0e, 8'h99, 8'h99, 8'h51, 8'h0e,
        8'h99, 8'h99, 8'h51, 8'h0e, 8'h99, 8'h99, 8'h51, 8'h0e,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h99, 8'hee, 8'hee, 8'hb5, 8'ha1, 8'h00, 8'h00,
        8'h77, 8'h77, 8'h77, 8'h77, 8'h77, 8'h77, 8'h77, 8'h77,
        8'hba, 8'haa, 8'h99, 8'h99, 8'h99, 8'h99, 8'h99, 8'h99,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h06, 8'h00, 8'h00,
        8'h44, 8'h44, 8'h00, 8'h00, 8'h51, 8'h00, 8'h00, 8'h00,
        8'h11, 8'h11, 8'h11, 8'h11, 8'h55, 8'h55, 8'h55, 8'h55,
        8'haa, 8'h02, 8'h99, 8'hba, 8'h03, 8'h02, 8'h10, 8'h00,
        8'h99, 8'h99, 8'h11, 8'h00, 8'hff, 8'hff, 8'hff, 8'hff,
        8'h77, 8'h77, 8'h11, 8'h11, 8'h88, 8'h76, 8'h00, 8'h00,
        8'h0e, 8'hee, 8'h00, 8'hdc, 8'h00, 8'h00, 8'h00, 8'h99
    };

    localparam logic [7:0] CLASS_TAB_64 [128] = '{
        8'h99, 8'h99, 8'h51, 8'hff, 8'h99, 8'h99, 8'h51, 8'hf0,
        8'h99, 8'h99, 8'h51, 8'hff, 8'h99, 8'h99, 8'h51, 8'hff,
        8'h99, 8'h99, 8'h51, 8'hfe, 8'h99, 8'h99, 8'h51, 8'hfe,
        8'h99, 8'h99, 8'h51, 8'h0e, 8'h99, 8'h99, 8'h51, 8'h0e,
        8'hee, 8'hee, 8'hee, 8'hee, 8'hee, 8'hee, 8'hee, 8'hee,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'hff, 8'h9f, 8'hee, 8'hee, 8'hb5, 8'ha1, 8'h00, 8'h00,
        8'h77, 8'h77, 8'h77, 8'h77, 8'h77, 8'h77, 8'h77, 8'h77,
        8'hba, 8'haf, 8'h99, 8'h99, 8'h99, 8'h99, 8'h99, 8'h99,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h0f, 8'h00, 8'h00,
        8'h44, 8'h44, 8'h00, 8'h00, 8'h51, 8'h00, 8'h00, 8'h00,
        8'h11, 8'h11, 8'h11, 8'h11, 8'h66, 8'h66, 8'h66, 8'h66,
        8'haa, 8'h02, 8'hff, 8'hba, 8'h03, 8'h02, 8'h10, 8'h00,
        8'h99, 8'h99, 8'hff, 8'h0f, 8'hff, 8'hff, 8'hff, 8'hff,
        8'h77, 8'h77, 8'h11, 8'h11, 8'h88, 8'h7f, 8'h00, 8'h00,
        8'h0e, 8'hee, 8'h00, 8'hdc, 8'h00, 8'h00, 8'h00, 8'h99
    };

    // class of one opcode or prefix byte for the selected mode
    function automatic logic [3:0] class_of(input logic long_mode, input logic [7:0] b);
        logic [7:0] pair;
        pair = long_mode ? CLASS_TAB_64[b[7:1]] : CLASS_TAB_32[b[7:1]];
        return b[0] ? pair[7:4] : pair[3:0];
    endfunction

endpackage

>>> src/x86_instruction_length_decoder.sv
// x86 instruction length decoder top level: decode state, mode register, result stage
// Takes one code byte per cycle and reports each instruction from a result register once
// its last byte is accepted. The decode of a byte is a single pass through
// the class table and ModRM/SIB logic, so a byte is accepted every cycle; a result
// register with a one-entry skid buffer behind it keeps the byte side running while a
// result waits, and code_ready drops only when both hold a request. long_mode (reset 1)
// picks the 64-bit or 32-bit opcode table and takes effect from the next byte.
module x86_instruction_length_decoder
    import ild_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_data,
    input  logic       code_valid,
    output logic       code_ready,
    input  logic [7:0] code_byte,
    output logic       result_valid,
    input  logic       result_ready,
    output logic [3:0] length,
    output logic       ip_rel,
    output logic [3:0] ip_rel_pos,
    output logic [2:0] ip_rel_len,
    output logic       unknown_op,
    output logic       too_long
);

    state_t  state_reg;
    state_t  state_next;
    logic    long_mode_reg;
    logic    done;
    result_t result_next;
    result_t out_reg;
    result_t skid_reg;
    logic    out_valid_reg;
    logic    skid_valid_reg;
    logic    code_take;
    logic    new_result;
    logic    out_free;

    // decode step
    ild_decode u_decode (
        .state      (state_reg),
        .long_mode  (long_mode_reg),
        .code_byte  (code_byte),
        .state_next (state_next),
        .done       (done),
        .result     (result_next)
    );

    assign code_ready = !skid_valid_reg;
    assign code_take  = code_valid && code_ready;
    assign new_result = code_take && done;
    assign out_free   = !out_valid_reg || result_ready;

    // mode register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            long_mode_reg <= 1'b1;
        else if (cfg_we)
            long_mode_reg <= cfg_data;
    end

    // decode state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= STATE_RESET;
        else if (code_take)
            state_reg <= state_next;
    end

    // result and skid valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg  <= skid_valid_reg || new_result;
            skid_valid_reg <= 1'b0;
        end
        else if (new_result)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // result and skid payload
    always_ff @(posedge clk)
    begin
        if (out_free)
            out_reg <= skid_valid_reg ? skid_reg : result_next;
        else if (new_result)
            skid_reg <= result_next;
    end

    assign result_valid = out_valid_reg;
    assign length       = out_reg.length;
    assign ip_rel       = out_reg.ip_rel;
    assign ip_rel_pos   = out_reg.ip_rel_pos;
    assign ip_rel_len   = out_reg.ip_rel_len;
    assign unknown_op   = out_reg.unknown_op;
    assign too_long     = out_reg.too_long;

    // skid entry only fills behind a held result
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid buffer holds a request with the result register empty");

    // a finished instruction restarts decoding from the prefix phase
    assert property (@(posedge clk) disable iff (!rst_n)
        new_result |=> (state_reg.bytes_seen == 4'd0) && (state_reg.phase == PH_PREFIX))
        else $error("decode state not cleared after a result");

    // unknown opcode reports no length
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && unknown_op |-> (length == 4'd0) && !too_long && !ip_rel)
        else $error("unknown opcode request carries a length");

    // a cut-off instruction reports the full limit
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && too_long |-> (length == 4'(MAX_LENGTH)) && (ip_rel_len == 3'd0))
        else $error("cut-off request with wrong length");

    // relative flag follows the field size
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (ip_rel == (ip_rel_len != 3'd0)))
        else $error("relative flag disagrees with relative field size");

endmodule

>>> src/ild_decode.sv
// one-byte decode step: next decode state and the finished instruction, if any
module ild_decode
    import ild_pkg::*;
(
    input  state_t     state,
    input  logic       long_mode,
    input  logic [7:0] code_byte,
    output state_t     state_next,
    output logic       done,
    output result_t    result
);

    logic [3:0] seen;
    logic [3:0] wide;
    logic [3:0] cls;
    logic [3:0] mcls;
    logic [3:0] imm;
    logic [3:0] disp;
    logic [3:0] far_len;
    logic       rip_form;
    logic       sib;
    state_t     work;

    // values shared by the phases
    assign seen     = state.bytes_seen + 4'd1;
    assign wide     = (state.size_mode != 2'd0) ? 4'd4 : 4'd2;
    assign cls      = class_of(long_mode, code_byte);
    assign far_len  = 4'(5'd2 << state.size_mode);
    assign rip_form = (code_byte[7:6] == 2'b00) && (code_byte[2:0] == 3'd5);

    // group F6/F7 carries an immediate only for reg 0 and 1
    always_comb
    begin
        mcls = state.op_class;
        if (state.op_class == CLS_GRP_I8 || state.op_class == CLS_GRP_IW)
        begin
            mcls = (code_byte[5:3] > 3'd1) ? CLS_NONE : state.op_class - 4'd2;
        end
        imm = (mcls == CLS_MODRM_I8) ? 4'd1 : ((mcls == CLS_MODRM_IW) ? wide : 4'd0);
    end

    // state update per phase
    always_comb
    begin
        work            = state;
        work.bytes_seen = seen;
        disp            = 4'd0;
        sib             = 1'b0;
        unique case (state.phase)
            PH_MODRM:
            begin
                work.modrm_byte = code_byte;
                if (code_byte[7:6] == 2'b11)
                begin
                    disp = 4'd0;
                end
                else if (long_mode && rip_form)
                begin
                    work.rel_pos   = seen;
                    work.rel_bytes = 3'd4;
                    disp           = 4'd4;
                end
                else
                begin
                    if (rip_form)
                        disp = 4'd4;
                    else if (code_byte[7:6] == 2'b01)
                        disp = 4'd1;
                    else if (code_byte[7:6] == 2'b10)
                        disp = 4'd4;
                    sib = (code_byte[2:0] == 3'd4);
                end
                work.bytes_left = disp + imm;
                work.phase      = sib ? PH_SIB : PH_TAIL;
            end
            PH_SIB:
            begin
                if (code_byte[2:0] == 3'd5 && state.modrm_byte[7:6] == 2'b00)
                    work.bytes_left = state.bytes_left + 4'd4;
                work.phase = PH_TAIL;
            end
            PH_TAIL:
            begin
                if (state.bytes_left != 4'd0)
                    work.bytes_left = state.bytes_left - 4'd1;
            end
            default:
            begin
                if (cls == CLS_PREFIX)
                begin
                    if (code_byte[7:4] == 4'h4)
                        work.size_mode = code_byte[3] ? 2'd2 : 2'd1;
                    else if (code_byte == 8'h66)
                        work.size_mode = 2'd0;
                end
                else if (cls != CLS_UNKNOWN)
                begin
                    work.phase = PH_TAIL;
                    if (cls <= 4'd3)
                    begin
                        work.bytes_left = cls;
                    end
                    else if (cls == CLS_ABS)
                    begin
                        work.bytes_left = long_mode ? 4'd8 : 4'd4;
                    end
                    else if (cls == CLS_IMMW)
                    begin
                        work.bytes_left = wide;
                    end
                    else if (cls == CLS_FAR)
                    begin
                        work.bytes_left = long_mode ? far_len : 4'd2 + wide;
                    end
                    else if (cls == CLS_REL8 || cls == CLS_RELW)
                    begin
                        work.rel_pos    = seen;
                        work.rel_bytes  = (cls == CLS_REL8) ? 3'd1 : wide[2:0];
                        work.bytes_left = (cls == CLS_REL8) ? 4'd1 : wide;
                    end
                    else
                    begin
                        work.op_class = cls;
                        work.phase    = PH_MODRM;
                    end
                end
            end
        endcase
    end

    // completion: unknown opcode, last byte, or cut off at the length limit
    always_comb
    begin
        done       = 1'b1;
        result     = '0;
        state_next = STATE_RESET;
        if ((state.phase != PH_MODRM) && (state.phase != PH_SIB) &&
            (state.phase != PH_TAIL) && (cls == CLS_UNKNOWN))
        begin
            result.unknown_op = 1'b1;
        end
        else if (work.phase == PH_TAIL && work.bytes_left == 4'd0)
        begin
            result.length     = seen;
            result.ip_rel_pos = work.rel_pos;
            result.ip_rel_len = work.rel_bytes;
            result.ip_rel     = (work.rel_bytes != 3'd0);
        end
        else if (seen >= 4'(MAX_LENGTH))
        begin
            result.length   = 4'(MAX_LENGTH);
            result.too_long = 1'b1;
        end
        else
        begin
            done       = 1'b0;
            state_next = work;
        end
    end

endmodule

>>> tb/tb_x86_instruction_length_decoder.sv
// self-checking testbench for the x86 instruction length decoder
`timescale 1ns / 1ps

module tb
    import ild_pkg::*;
();

    // modrm field values
    localparam logic [1:0] MOD_NODISP = 2'b00;
    localparam logic [1:0] MOD_DISP8  = 2'b01;
    localparam logic [1:0] MOD_DISP32 = 2'b10;
    localparam logic [1:0] MOD_REG    = 2'b11;
    localparam logic [2:0] RM_SIB     = 3'd4;
    localparam logic [2:0] RM_DISP32  = 3'd5;

    // class nibbles per opcode pair, low nibble even opcode, high nibble odd opcode
    localparam logic [7:0] OPC_CLASS_32 [128] = '{
        8'h99, 8'h99, 8'h51, 8'h00, 8'h99, 8'h99, 8'h51, 8'hf0,
        8'h99, 8'h99, 8'h51, 8'h00, 8'h99, 8'h99, 8'h51, 8'h00,
        8'h99, 8'h99, 8'h51, 8'h0e, 8'h99, 8'h99, 8'h51, 8'h0e,
        8'h99, 8'h99, 8'h51, 8'h0e, 8'h99, 8'h99, 8'h51, 8'h0e,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h99, 8'hee, 8'hee, 8'hb5, 8'ha1, 8'h00, 8'h00,
        8'h77, 8'h77, 8'h77, 8'h77, 8'h77, 8'h77, 8'h77, 8'h77,
        8'hba, 8'haa, 8'h99, 8'h99, 8'h99, 8'h99, 8'h99, 8'h99,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h06, 8'h00, 8'h00,
        8'h44, 8'h44, 8'h00, 8'h00, 8'h51, 8'h00, 8'h00, 8'h00,
        8'h11, 8'h11, 8'h11, 8'h11, 8'h55, 8'h55, 8'h55, 8'h55,
        8'haa, 8'h02, 8'h99, 8'hba, 8'h03, 8'h02, 8'h10, 8'h00,
        8'h99, 8'h99, 8'h11, 8'h00, 8'hff, 8'hff, 8'hff, 8'hff,
        8'h77, 8'h77, 8'h11, 8'h11, 8'h88, 8'h76, 8'h00, 8'h00,
        8'h0e, 8'hee, 8'h00, 8'hdc, 8'h00, 8'h00, 8'h00, 8'h99
    };

    localparam logic [7:0] OPC_CLASS_64 [128] = '{
        8'h99, 8'h99, 8'h51, 8'hff, 8'h99, 8'h99, 8'h51, 8'hf0,
        8'h99, 8'h99, 8'h51, 8'hff, 8'h99, 8'h99, 8'h51, 8'hff,
        8'h99, 8'h99, 8'h51, 8'hfe, 8'h99, 8'h99, 8'h51, 8'hfe,
        8'h99, 8'h99, 8'h51, 8'h0e, 8'h99, 8'h99, 8'h51, 8'h0e,
        8'hee, 8'hee, 8'hee, 8'hee, 8'hee, 8'hee, 8'hee, 8'hee,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'hff, 8'h9f, 8'hee, 8'hee, 8'hb5, 8'ha1, 8'h00, 8'h00,
        8'h77, 8'h77, 8'h77, 8'h77, 8'h77, 8'h77, 8'h77, 8'h77,
        8'hba, 8'haf, 8'h99, 8'h99, 8'h99, 8'h99, 8'h99, 8'h99,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h0f, 8'h00, 8'h00,
        8'h44, 8'h44, 8'h00, 8'h00, 8'h51, 8'h00, 8'h00, 8'h00,
        8'h11, 8'h11, 8'h11, 8'h11, 8'h66, 8'h66, 8'h66, 8'h66,
        8'haa, 8'h02, 8'hff, 8'hba, 8'h03, 8'h02, 8'h10, 8'h00,
        8'h99, 8'h99, 8'hff, 8'h0f, 8'hff, 8'hff, 8'hff, 8'hff,
        8'h77, 8'h77, 8'h11, 8'h11, 8'h88, 8'h7f, 8'h00, 8'h00,
        8'h0e, 8'hee, 8'h00, 8'hdc, 8'h00, 8'h00, 8'h00, 8'h99
    };

    // legacy prefixes; rex prefixes are built separately
    localparam logic [7:0] PREFIX_BYTES [11] = '{
        8'h66, 8'h67, 8'hf0, 8'hf2, 8'hf3, 8'h2e, 8'h3e, 8'h26, 8'h36, 8'h64, 8'h65
    };

    // opcodes that reach the modrm, immediate and branch paths
    localparam logic [7:0] RICH_OPCODES [24] = '{
        8'h80, 8'h81, 8'h83, 8'hc6, 8'hc7, 8'hf6, 8'hf7, 8'h69,
        8'h6b, 8'he8, 8'he9, 8'heb, 8'h74, 8'h9a, 8'hea, 8'ha0,
        8'ha1, 8'hb8, 8'h68, 8'h6a, 8'hc2, 8'hcd, 8'h8b, 8'h8d
    };

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_we = 1'b0;
    logic       cfg_data = 1'b0;
    logic       code_valid = 1'b0;
    logic       code_ready;
    logic [7:0] code_byte = 8'h00;
    logic       result_valid;
    logic       result_ready = 1'b0;
    logic [3:0] length;
    logic       ip_rel;
    logic [3:0] ip_rel_pos;
    logic [2:0] ip_rel_len;
    logic       unknown_op;
    logic       too_long;

    // shadow decode state
    logic       mode_shadow = 1'b1;
    phase_t     dec_phase = PH_PREFIX;
    logic [3:0] dec_class = 4'd0;
    logic [1:0] dec_size = 2'd1;
    logic [7:0] dec_modrm = 8'd0;
    logic [3:0] dec_seen = 4'd0;
    logic [3:0] dec_left = 4'd0;
    logic [3:0] dec_rel_pos = 4'd0;
    logic [2:0] dec_rel_bytes = 3'd0;

    result_t expected_instrs [$];

    int  err_count = 0;
    int  n_bytes = 0;
    int  n_instr = 0;
    int  n_rel = 0;
    int  n_unknown = 0;
    int  n_cut = 0;
    bit  bursts_on = 1'b1;
    bit  idle_allowed = 1'b1;
    int  hold_request = 0;
    int  hold_left = 0;
    int  rx_burst = 0;

    x86_instruction_length_decoder uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .code_valid   (code_valid),
        .code_ready   (code_ready),
        .code_byte    (code_byte),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .length       (length),
        .ip_rel       (ip_rel),
        .ip_rel_pos   (ip_rel_pos),
        .ip_rel_len   (ip_rel_len),
        .unknown_op   (unknown_op),
        .too_long     (too_long)
    );

    // clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // run limit
    initial
    begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // advance the shadow decoder by one code byte
    task automatic decode_byte(input logic [7:0] b, output bit done, output result_t r);
        logic [7:0] pair;
        logic [7:0] shifted;
        logic [3:0] cls;
        logic [3:0] wide;
        logic [3:0] disp;
        logic [3:0] imm;
        bit         sib;
        done = 1'b0;
        r = '0;
        sib = 1'b0;
        wide = (dec_size != 2'd0) ? 4'd4 : 4'd2;
        dec_seen = dec_seen + 4'd1;
        case (dec_phase)
            PH_MODRM:
            begin
                dec_modrm = b;
                cls = dec_class;
                // group f6/f7 style: immediate only for reg 0 and 1
                if (cls == CLS_GRP_I8 || cls == CLS_GRP_IW)
                begin
                    if (b[5:3] > 3'd1)
                        cls = CLS_NONE;
                    else
                        cls = cls - 4'd2;
                end
                imm = (cls == CLS_MODRM_I8) ? 4'd1 : ((cls == CLS_MODRM_IW) ? wide : 4'd0);
                disp = 4'd0;
                if (b[7:6] == MOD_REG)
                    disp = 4'd0;
                else if (mode_shadow && b[7:6] == MOD_NODISP && b[2:0] == RM_DISP32)
                begin
                    // rip-relative displacement
                    dec_rel_pos = dec_seen;
                    dec_rel_bytes = 3'd4;
                    disp = 4'd4;
                end
                else
                begin
                    if (b[7:6] == MOD_NODISP && b[2:0] == RM_DISP32)
                        disp = 4'd4;
                    else if (b[7:6] == MOD_DISP8)
                        disp = 4'd1;
                    else if (b[7:6] == MOD_DISP32)
                        disp = 4'd4;
                    sib = (b[2:0] == RM_SIB);
                end
                dec_left = disp + imm;
                dec_phase = sib ? PH_SIB : PH_TAIL;
            end
            PH_SIB:
            begin
                // no base register: disp32 follows
                if (b[2:0] == RM_DISP32 && dec_modrm[7:6] == MOD_NODISP)
                    dec_left = dec_left + 4'd4;
                dec_phase = PH_TAIL;
            end
            PH_TAIL:
            begin
                if (dec_left != 4'd0)
                    dec_left = dec_left - 4'd1;
            end
            default:
            begin
                pair = mode_shadow ? OPC_CLASS_64[b[7:1]] : OPC_CLASS_32[b[7:1]];
                cls = b[0] ? pair[7:4] : pair[3:0];
                if (cls == CLS_PREFIX)
                begin
                    if (b[7:4] == 4'h4)
                        dec_size = b[3] ? 2'd2 : 2'd1;
                    else if (b == 8'h66)
                        dec_size = 2'd0;
                end
                else if (cls == CLS_UNKNOWN)
                begin
                    r.unknown_op = 1'b1;
                    done = 1'b1;
                end
                else
                begin
                    dec_phase = PH_TAIL;
                    if (cls <= 4'd3)
                        dec_left = cls;
                    else if (cls == CLS_ABS)
                        dec_left = mode_shadow ? 4'd8 : 4'd4;
                    else if (cls == CLS_IMMW)
                        dec_left = wide;
                    else if (cls == CLS_FAR)
                    begin
                        shifted = 8'd2 << dec_size;
                        dec_left = mode_shadow ? shifted[3:0] : 4'd2 + wide;
                    end
                    else if (cls == CLS_REL8 || cls == CLS_RELW)
                    begin
                        dec_rel_pos = dec_seen;
                        dec_rel_bytes = (cls == CLS_REL8) ? 3'd1 : wide[2:0];
                        dec_left = {1'b0, dec_rel_bytes};
                    end
                    else
                    begin
                        dec_class = cls;
                        dec_phase = PH_MODRM;
                    end
                end
            end
        endcase
        if (!done)
        begin
            if (dec_phase == PH_TAIL && dec_left == 4'd0)
            begin
                r.length = dec_seen;
                r.ip_rel = (dec_rel_bytes != 3'd0);
                r.ip_rel_pos = dec_rel_pos;
                r.ip_rel_len = dec_rel_bytes;
                done = 1'b1;
            end
            else if (dec_seen >= 4'(MAX_LENGTH))
            begin
                r.length = 4'(MAX_LENGTH);
                r.too_long = 1'b1;
                done = 1'b1;
            end
        end
        // instruction finished: start over
        if (done)
        begin
            n_instr++;
            if (r.ip_rel)
                n_rel++;
            if (r.unknown_op)
                n_unknown++;
            if (r.too_long)
                n_cut++;
            dec_phase = PH_PREFIX;
            dec_class = 4'd0;
            dec_size = 2'd1;
            dec_modrm = 8'd0;
            dec_seen = 4'd0;
            dec_left = 4'd0;
            dec_rel_pos = 4'd0;
            dec_rel_bytes = 3'd0;
        end
    endtask

    // offer one code byte, wait for the request to be taken, record what it finishes
    task automatic send_byte(input logic [7:0] b, output bit done);
        result_t r;
        int      gap;
        if (bursts_on && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 19);
            @(negedge clk);
            code_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        code_valid <= 1'b1;
        code_byte <= b;
        @(posedge clk);
        while (!code_ready)
            @(posedge clk);
        decode_byte(b, done, r);
        if (done)
            expected_instrs.push_back(r);
        n_bytes++;
    endtask

    // stop offering and wait until every instruction has been reported
    task automatic drain_results();
        @(negedge clk);
        code_valid <= 1'b0;
        while (expected_instrs.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // mode register write while the byte side is quiet
    task automatic set_long_mode(input logic m);
        drain_results();
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_data <= m;
        @(posedge clk);
        mode_shadow = m;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [7:0] random_prefix();
        logic [3:0] rex_bits;
        rex_bits = 4'($urandom_range(0, 15));
        if ($urandom_range(0, 11) == 11)
            return {4'h4, rex_bits};
        return PREFIX_BYTES[$urandom_range(0, 10)];
    endfunction

    // one instruction: a few prefixes, an opcode, then random bytes until it ends
    task automatic send_instruction();
        int npfx;
        bit d;
        npfx = ($urandom_range(0, 4) < 3) ? 0 : $urandom_range(1, 3);
        repeat (npfx) send_byte(random_prefix(), d);
        if ($urandom_range(0, 2) == 0)
            send_byte(RICH_OPCODES[$urandom_range(0, 23)], d);
        else
            send_byte(8'($urandom_range(0, 255)), d);
        while (!d)
            send_byte(8'($urandom_range(0, 255)), d);
    endtask

    // zero and all-ones bytes, unknown opcode, rip-relative operand in 64-bit mode
    task automatic test_long_mode_basics();
        bit d;
        set_long_mode(1'b1);
        send_byte(8'h00, d);
        send_byte(8'hc0, d);
        send_byte(8'hff, d);
        send_byte(8'hff, d);
        send_byte(8'h06, d);
        send_byte(8'h8b, d);
        send_byte(8'h05, d);
        repeat (4) send_byte(8'($urandom_range(0, 255)), d);
    endtask

    // an instruction that never ends gets cut off at the length limit
    task automatic test_length_limit();
        bit d;
        repeat (15) send_byte(8'h66, d);
    endtask

    // mode register changed between the prefix and the opcode
    task automatic test_mode_switch_midway();
        bit d;
        send_byte(8'h66, d);
        set_long_mode(1'b0);
        send_byte(8'ha0, d);
        repeat (4) send_byte(8'($urandom_range(0, 255)), d);
    endtask

    // 16-bit relative call and the group immediate case in 32-bit mode
    task automatic test_legacy_forms();
        bit d;
        send_byte(8'h66, d);
        send_byte(8'he8, d);
        repeat (2) send_byte(8'($urandom_range(0, 255)), d);
        send_byte(8'hf6, d);
        send_byte(8'h08, d);
        send_byte(8'($urandom_range(0, 255)), d);
    endtask

    // result side held off for a long time while requests keep coming
    task automatic test_backpressure();
        bursts_on = 1'b0;
        set_long_mode(1'b1);
        hold_request = 150;
        repeat (25) send_instruction();
        drain_results();
        bursts_on = 1'b1;
    endtask

    // mostly real instruction shapes, some raw noise and runaway prefix chains
    task automatic test_random_stream(input logic m, input int count);
        int stop_at;
        int pick;
        bit d;
        set_long_mode(m);
        stop_at = n_bytes + count;
        while (n_bytes < stop_at)
        begin
            if ($urandom_range(0, 49) == 0)
                bursts_on = idle_allowed && ($urandom_range(0, 2) != 0);
            pick = $urandom_range(0, 19);
            if (pick < 16)
                send_instruction();
            else if (pick < 19)
                repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)), d);
            else
                repeat ($urandom_range(13, 16)) send_byte(random_prefix(), d);
        end
    endtask

    // result side: random stalls and the long hold-off
    always @(negedge clk)
    begin : rx_side
        bit rdy;
        rdy = 1'b1;
        if (hold_request > 0)
        begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            rdy = 1'b0;
        end
        else if (rx_burst > 0)
        begin
            rx_burst--;
            rdy = 1'b0;
        end
        else if (bursts_on && $urandom_range(0, 9) == 0)
        begin
            rx_burst = $urandom_range(1, 19) - 1;
            rdy = 1'b0;
        end
        result_ready <= rdy;
    end

    // compare each reported instruction with the oldest prediction
    always @(posedge clk)
    begin : check_results
        result_t got;
        result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            got = {length, ip_rel, ip_rel_pos, ip_rel_len, unknown_op, too_long};
            if (expected_instrs.size() == 0)
            begin
                err_count++;
                if (err_count <= 10)
                    $display("%0t: unexpected len %0d rel %0b off %0d size %0d unk %0b long %0b",
                             $time, got.length, got.ip_rel, got.ip_rel_pos,
                             got.ip_rel_len, got.unknown_op, got.too_long);
            end
            else
            begin
                want = expected_instrs.pop_front();
                if (got !== want)
                begin
                    err_count++;
                    if (err_count <= 10)
                    begin
                        $display("%0t: expected len %0d rel %0b off %0d size %0d unk %0b long %0b",
                                 $time, want.length, want.ip_rel, want.ip_rel_pos,
                                 want.ip_rel_len, want.unknown_op, want.too_long);
                        $display("%0t:      got len %0d rel %0b off %0d size %0d unk %0b long %0b",
                                 $time, got.length, got.ip_rel, got.ip_rel_pos,
                                 got.ip_rel_len, got.unknown_op, got.too_long);
                    end
                end
            end
        end
    end

    // test sequence
    initial
    begin
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        test_long_mode_basics();
        test_length_limit();
        test_mode_switch_midway();
        test_legacy_forms();
        test_backpressure();
        test_random_stream(1'b1, 500);
        test_random_stream(1'b0, 500);
        test_random_stream(1'b1, 400);
        idle_allowed = 1'b0;
        bursts_on = 1'b0;
        test_random_stream(1'b0, 300);

        drain_results();
        repeat (8) @(posedge clk);
        $display("%0d code bytes in 64-bit and 32-bit mode, %0d instructions reported",
                 n_bytes, n_instr);
        $display("%0d with a relative field, %0d unknown opcodes, %0d cut off at the limit",
                 n_rel, n_unknown, n_cut);
        if (err_count == 0 && expected_instrs.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

>>> files.f
src/ild_pkg.sv
src/ild_decode.sv
src/x86_instruction_length_decoder.sv
tb/tb_x86_instruction_length_decoder.sv
